// ===== hdl/pid_with_windowed_integral_macros.svh =====
`ifndef PID_WITH_WINDOWED_INTEGRAL_MACROS_SVH
`define PID_WITH_WINDOWED_INTEGRAL_MACROS_SVH

// Same-cycle check: whenever ANTE holds, CONS must hold too.
`define PWI_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: whenever ANTE holds, CONS must hold in the next cycle.
`define PWI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pwi_pkg.sv =====
`timescale 1ns / 1ps

package pwi_pkg;

  localparam int DATA_W    = 16;
  localparam int ERR_W     = DATA_W + 1;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int SUM_W     = 32;
  localparam int GAIN_W    = 24;
  localparam int WIN_W     = 16;
  localparam int LIM_W     = 15;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_BITS = 14;

  // Gains are widened by a zero bit so they multiply as signed values.
  localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
  localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W    = PROD_I_W + 2;
  localparam int SHIFT_W  = ACC_W - FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P        = 3'd0,
    CFG_GAIN_I        = 3'd1,
    CFG_GAIN_D        = 3'd2,
    CFG_INT_WINDOW    = 3'd3,
    CFG_DRIVE_LIMIT   = 3'd4,
    CFG_MARKER_HOLD   = 3'd5
  } cfg_idx_t;

  localparam logic [GAIN_W-1:0] GAIN_P_RST      = 24'd155648;
  localparam logic [GAIN_W-1:0] GAIN_I_RST      = 24'd410;
  localparam logic [GAIN_W-1:0] GAIN_D_RST      = 24'd16384;
  localparam logic [WIN_W-1:0]  INT_WINDOW_RST  = 16'd900;
  localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST = 15'd5000;
  localparam logic              MARKER_HOLD_RST = 1'b1;

  localparam logic signed [DATA_W-1:0] MARKER_VALUE = -16'sd3;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [WIN_W-1:0]  integrate_window;
    logic [LIM_W-1:0]  drive_limit;
    logic              marker_hold_enable;
  } pwi_cfg_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic s4_load;
  } pwi_load_t;

endpackage

// ===== hdl/pid_with_windowed_integral.sv =====
`timescale 1ns / 1ps
// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// input    | in_valid, in_stall, in_setpoint, in_measured | in
// result   | out_valid, out_stall, out_drive, out_clamped | out
// config   | cfg_wr_en, cfg_index, cfg_wdata          | in
//
// One transaction is accepted per cycle while in_stall is low; a result passes through
// the input register, error and integral stage, multiplier stage, sum stage and clamp stage.
// The integral and previous error update once per transaction in the error stage.
// Reset (rst_n low, synchronous) clears the pipeline, the integral and the config
// registers to their defaults.
// A stalled result holds the output register; earlier stages keep filling bubbles,
// and in_stall rises only once every stage holds a transaction.

module pid_with_windowed_integral (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pwi_pkg::DATA_W-1:0]    in_setpoint,
  input  logic signed [pwi_pkg::DATA_W-1:0]    in_measured,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pwi_pkg::DATA_W-1:0]    out_drive,
  output logic                                 out_clamped,
  input  logic                                 cfg_wr_en,
  input  logic        [pwi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [pwi_pkg::CFG_W-1:0]     cfg_wdata
);
  import pwi_pkg::*;

`include "pid_with_windowed_integral_macros.svh"

  pwi_cfg_t  cfg_r;
  pwi_load_t load;

  logic in_vld_r, s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  logic signed [DATA_W-1:0] setpoint_r, measured_r;

  logic signed [ERR_W-1:0]    err;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [SUM_W-1:0]    error_sum;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p             <= GAIN_P_RST;
      cfg_r.gain_i             <= GAIN_I_RST;
      cfg_r.gain_d             <= GAIN_D_RST;
      cfg_r.integrate_window   <= INT_WINDOW_RST;
      cfg_r.drive_limit        <= DRIVE_LIMIT_RST;
      cfg_r.marker_hold_enable <= MARKER_HOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GAIN_P:      cfg_r.gain_p             <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_I:      cfg_r.gain_i             <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_D:      cfg_r.gain_d             <= cfg_wdata[GAIN_W-1:0];
        CFG_INT_WINDOW:  cfg_r.integrate_window   <= cfg_wdata[WIN_W-1:0];
        CFG_DRIVE_LIMIT: cfg_r.drive_limit        <= cfg_wdata[LIM_W-1:0];
        CFG_MARKER_HOLD: cfg_r.marker_hold_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // A stage can take a new transaction when it is empty or its content moves on.
  always_comb begin
    rdy4 = !out_vld_r || !out_stall;
    rdy3 = !s3_vld_r  || rdy4;
    rdy2 = !s2_vld_r  || rdy3;
    rdy1 = !s1_vld_r  || rdy2;
    rdy0 = !in_vld_r  || rdy1;
    load.s1_load = in_vld_r && rdy1;
    load.s2_load = s1_vld_r && rdy2;
    load.s3_load = s2_vld_r && rdy3;
    load.s4_load = s3_vld_r && rdy4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy0) in_vld_r  <= in_valid;
      if (rdy1) s1_vld_r  <= in_vld_r;
      if (rdy2) s2_vld_r  <= s1_vld_r;
      if (rdy3) s3_vld_r  <= s2_vld_r;
      if (rdy4) out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      setpoint_r <= in_setpoint;
      measured_r <= in_measured;
    end
  end

  pwi_integ u_integ (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .cfg       (cfg_r),
    .setpoint  (setpoint_r),
    .measured  (measured_r),
    .err       (err),
    .diff      (diff),
    .error_sum (error_sum)
  );

  pwi_mult u_mult (
    .clk       (clk),
    .load      (load),
    .cfg       (cfg_r),
    .err       (err),
    .diff      (diff),
    .error_sum (error_sum),
    .prod_p    (prod_p),
    .prod_i    (prod_i),
    .prod_d    (prod_d)
  );

  pwi_drive u_drive (
    .clk     (clk),
    .load    (load),
    .cfg     (cfg_r),
    .prod_p  (prod_p),
    .prod_i  (prod_i),
    .prod_d  (prod_d),
    .drive   (out_drive),
    .clamped (out_clamped)
  );

  assign in_stall  = !rdy0;
  assign out_valid = out_vld_r;

  `PWI_ASSERT_HOLDS(a_drive_in_limit, out_vld_r,
    ($signed(out_drive) <= $signed({1'b0, cfg_r.drive_limit})) &&
    ($signed(out_drive) >= -$signed({1'b0, cfg_r.drive_limit})),
    "drive lies outside the configured limit")
  `PWI_ASSERT_HOLDS(a_clamp_at_limit, out_vld_r && out_clamped,
    ($signed(out_drive) == $signed({1'b0, cfg_r.drive_limit})) ||
    ($signed(out_drive) == -$signed({1'b0, cfg_r.drive_limit})),
    "clamped result is not at the limit")
  `PWI_ASSERT_NEXT(a_no_repeat, out_vld_r && !out_stall && !s3_vld_r, !out_vld_r,
    "result repeated after it was taken")

endmodule

// ===== hdl/pwi_integ.sv =====
`timescale 1ns / 1ps

module pwi_integ (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pwi_pkg::pwi_load_t                  load,
  input  pwi_pkg::pwi_cfg_t                   cfg,
  input  logic signed [pwi_pkg::DATA_W-1:0]   setpoint,
  input  logic signed [pwi_pkg::DATA_W-1:0]   measured,
  output logic signed [pwi_pkg::ERR_W-1:0]    err,
  output logic signed [pwi_pkg::DIFF_W-1:0]   diff,
  output logic signed [pwi_pkg::SUM_W-1:0]    error_sum
);
  import pwi_pkg::*;

  // err_r also serves as the previous error for the next transaction.
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [SUM_W-1:0]  error_sum_r, error_sum_nxt;
  logic        [ERR_W-1:0]  err_mag;
  logic signed [SUM_W:0]    sum_wide;
  logic                     in_window;
  logic                     hold;

  always_comb begin
    err_nxt   = $signed({setpoint[DATA_W-1], setpoint}) - $signed({measured[DATA_W-1], measured});
    err_mag   = err_nxt[ERR_W-1] ? $unsigned(-err_nxt) : $unsigned(err_nxt);
    in_window = err_mag < {1'b0, cfg.integrate_window};
    hold      = cfg.marker_hold_enable && (measured == MARKER_VALUE);
    diff_nxt  = $signed({err_nxt[ERR_W-1], err_nxt}) - $signed({err_r[ERR_W-1], err_r});

    sum_wide = $signed({error_sum_r[SUM_W-1], error_sum_r})
             + $signed({{(SUM_W + 1 - ERR_W){err_nxt[ERR_W-1]}}, err_nxt});

    error_sum_nxt = error_sum_r;
    if (in_window && !hold) begin
      // Overflow shows as the two top bits of the widened sum disagreeing.
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
        error_sum_nxt = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        error_sum_nxt = sum_wide[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r       <= '0;
      error_sum_r <= '0;
    end else if (load.s1_load) begin
      err_r       <= err_nxt;
      error_sum_r <= error_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load.s1_load) begin
      diff_r <= diff_nxt;
    end
  end

  assign err       = err_r;
  assign diff      = diff_r;
  assign error_sum = error_sum_r;

endmodule

// ===== hdl/pwi_mult.sv =====
`timescale 1ns / 1ps

module pwi_mult (
  input  logic                                  clk,
  input  pwi_pkg::pwi_load_t                    load,
  input  pwi_pkg::pwi_cfg_t                     cfg,
  input  logic signed [pwi_pkg::ERR_W-1:0]      err,
  input  logic signed [pwi_pkg::DIFF_W-1:0]     diff,
  input  logic signed [pwi_pkg::SUM_W-1:0]      error_sum,
  output logic signed [pwi_pkg::PROD_P_W-1:0]   prod_p,
  output logic signed [pwi_pkg::PROD_I_W-1:0]   prod_i,
  output logic signed [pwi_pkg::PROD_D_W-1:0]   prod_d
);
  import pwi_pkg::*;

  logic signed [PROD_P_W-1:0] prod_p_r;
  logic signed [PROD_I_W-1:0] prod_i_r;
  logic signed [PROD_D_W-1:0] prod_d_r;

  always_ff @(posedge clk) begin
    if (load.s2_load) begin
      prod_p_r <= $signed({1'b0, cfg.gain_p}) * err;
      prod_i_r <= $signed({1'b0, cfg.gain_i}) * error_sum;
      prod_d_r <= $signed({1'b0, cfg.gain_d}) * diff;
    end
  end

  assign prod_p = prod_p_r;
  assign prod_i = prod_i_r;
  assign prod_d = prod_d_r;

endmodule

// ===== hdl/pwi_drive.sv =====
`timescale 1ns / 1ps

module pwi_drive (
  input  logic                                  clk,
  input  pwi_pkg::pwi_load_t                    load,
  input  pwi_pkg::pwi_cfg_t                     cfg,
  input  logic signed [pwi_pkg::PROD_P_W-1:0]   prod_p,
  input  logic signed [pwi_pkg::PROD_I_W-1:0]   prod_i,
  input  logic signed [pwi_pkg::PROD_D_W-1:0]   prod_d,
  output logic signed [pwi_pkg::DATA_W-1:0]     drive,
  output logic                                  clamped
);
  import pwi_pkg::*;

  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [SHIFT_W-1:0] shifted;
  logic signed [SHIFT_W-1:0] lim;
  logic signed [DATA_W-1:0]  drive_r, drive_nxt;
  logic                      clamped_r, clamped_nxt;

  always_comb begin
    acc_nxt = $signed({{(ACC_W - PROD_P_W){prod_p[PROD_P_W-1]}}, prod_p})
            + $signed({{(ACC_W - PROD_I_W){prod_i[PROD_I_W-1]}}, prod_i})
            + $signed({{(ACC_W - PROD_D_W){prod_d[PROD_D_W-1]}}, prod_d});
  end

  always_comb begin
    // Dropping the fraction bits of a two's complement value is a floor.
    shifted = acc_r[ACC_W-1:FRAC_BITS];
    lim     = $signed({{(SHIFT_W - LIM_W){1'b0}}, cfg.drive_limit});
    if (shifted > lim) begin
      drive_nxt   = lim[DATA_W-1:0];
      clamped_nxt = 1'b1;
    end else if (shifted < -lim) begin
      drive_nxt   = -$signed(lim[DATA_W-1:0]);
      clamped_nxt = 1'b1;
    end else begin
      drive_nxt   = shifted[DATA_W-1:0];
      clamped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load.s3_load) begin
      acc_r <= acc_nxt;
    end
    if (load.s4_load) begin
      drive_r   <= drive_nxt;
      clamped_r <= clamped_nxt;
    end
  end

  assign drive   = drive_r;
  assign clamped = clamped_r;

endmodule

// ===== dv/tb_pid_with_windowed_integral.sv =====
`timescale 1ns / 1ps

module tb_pid_with_windowed_integral;
  import pwi_pkg::*;

  // Register indexes that have no register behind them; writes must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -(longint'(1) <<< (SUM_W - 1));

  typedef struct {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
    bit                       drain;
  } sample_t;

  typedef struct {
    logic signed [DATA_W-1:0] drive;
    logic                     clamped;
  } drive_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [DATA_W-1:0]   in_setpoint = '0;
  logic signed [DATA_W-1:0]   in_measured = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [DATA_W-1:0]   out_drive;
  logic                       out_clamped;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_wdata = '0;

  sample_t pending_samples[$];
  drive_t  expected_drive_q[$];

  pwi_cfg_t                 cfg_model;
  logic signed [SUM_W-1:0]  integ_model;
  logic signed [ERR_W-1:0]  prev_err_model;

  int sent_cnt = 0;
  int taken_cnt = 0;
  int results_seen = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int last_sp = 0;
  int last_meas = 0;
  bit no_idle = 1'b0;

  pid_with_windowed_integral dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_setpoint (in_setpoint),
    .in_measured (in_measured),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_drive   (out_drive),
    .out_clamped (out_clamped),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 19);
  endfunction

  // One controller step: windowed saturating integral, PID sum, floor shift, clamp.
  function automatic drive_t pid_step_predict(logic signed [DATA_W-1:0] sp,
                                              logic signed [DATA_W-1:0] meas);
    longint err, mag, s, acc, shaped, lim;
    drive_t r;
    err = longint'(sp) - longint'(meas);
    mag = (err < 0) ? -err : err;
    if (mag < longint'(cfg_model.integrate_window) &&
        !(cfg_model.marker_hold_enable && meas == MARKER_VALUE)) begin
      s = longint'(integ_model) + err;
      if (s > SUM_MAX) s = SUM_MAX;
      if (s < SUM_MIN) s = SUM_MIN;
      integ_model = s[SUM_W-1:0];
    end
    acc = longint'(cfg_model.gain_p) * err
        + longint'(cfg_model.gain_i) * longint'(integ_model)
        + longint'(cfg_model.gain_d) * (err - longint'(prev_err_model));
    prev_err_model = err[ERR_W-1:0];
    shaped = acc >>> FRAC_BITS;
    lim = longint'(cfg_model.drive_limit);
    r.clamped = 1'b0;
    if (shaped > lim) begin
      shaped = lim;
      r.clamped = 1'b1;
    end
    if (shaped < -lim) begin
      shaped = -lim;
      r.clamped = 1'b1;
    end
    r.drive = shaped[DATA_W-1:0];
    return r;
  endfunction

  function automatic void flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void queue_sample(int sp, int meas, bit drain);
    sample_t smp;
    smp.setpoint = sp[DATA_W-1:0];
    smp.measured = meas[DATA_W-1:0];
    smp.drain = drain;
    pending_samples.push_back(smp);
    last_sp = sp;
    last_meas = meas;
  endfunction

  // Errors around the integration window and full-range noise, four tenths each,
  // and the rest markers and repeats.
  function automatic void queue_random_sample(bit drain);
    int sp, meas, span;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        span = int'(cfg_model.integrate_window) + 2;
        if (span > 30000) span = 30000;
        meas = int'($urandom_range(0, 2000)) - 1000;
        sp = meas + int'($urandom_range(0, 2 * span)) - span;
        if (sp > 32767) sp = 32767;
        if (sp < -32768) sp = -32768;
      end
      4: begin
        meas = int'(MARKER_VALUE);
        sp = $urandom_range(0, 1) ? int'($urandom_range(0, 2000)) - 1000
                                  : int'($urandom_range(0, 65535)) - 32768;
      end
      5: begin
        sp = last_sp;
        meas = last_meas;
      end
      default: begin
        sp = int'($urandom_range(0, 65535)) - 32768;
        meas = int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    queue_sample(sp, meas, drain);
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return CFG_W'($urandom_range(0, 32768));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  task automatic wait_drained(int settle);
    while (pending_samples.size() != 0 || sent_cnt != taken_cnt ||
           expected_drive_q.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_GAIN_P:      cfg_model.gain_p = val[GAIN_W-1:0];
      CFG_GAIN_I:      cfg_model.gain_i = val[GAIN_W-1:0];
      CFG_GAIN_D:      cfg_model.gain_d = val[GAIN_W-1:0];
      CFG_INT_WINDOW:  cfg_model.integrate_window = val[WIN_W-1:0];
      CFG_DRIVE_LIMIT: cfg_model.drive_limit = val[LIM_W-1:0];
      CFG_MARKER_HOLD: cfg_model.marker_hold_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [CFG_W-1:0] gp, logic [CFG_W-1:0] gi,
                               logic [CFG_W-1:0] gd, logic [CFG_W-1:0] win,
                               logic [CFG_W-1:0] lim, logic [CFG_W-1:0] mh);
    write_reg(CFG_GAIN_P, gp);
    write_reg(CFG_GAIN_I, gi);
    write_reg(CFG_GAIN_D, gd);
    write_reg(CFG_INT_WINDOW, win);
    write_reg(CFG_DRIVE_LIMIT, lim);
    write_reg(CFG_MARKER_HOLD, mh);
  endtask

  task automatic run_random_phase(int n);
    for (int i = 0; i < n; i++) queue_random_sample(i == n / 2);
    wait_drained(SETTLE_CYCLES);
  endtask

  // Setpoint/measurement driver.
  always @(negedge clk) begin
    sample_t nxt;
    int gap_left;
    if (rst_n) begin
      if (in_valid && sent_cnt != taken_cnt) begin
        // Transaction still waiting on in_stall; hold the payload.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0 &&
                   !(pending_samples[0].drain && expected_drive_q.size() != 0)) begin
        nxt = pending_samples.pop_front();
        in_setpoint <= nxt.setpoint;
        in_measured <= nxt.measured;
        in_valid <= 1'b1;
        sent_cnt++;
        gap_left = draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_drive_q.push_back(pid_step_predict(in_setpoint, in_measured));
      taken_cnt++;
    end
  end

  // Result-side backpressure: a fresh stall length after every transaction.
  always @(negedge clk) begin
    int stall_left;
    int stall_drawn_at;
    if (results_seen != stall_drawn_at) begin
      stall_left = draw_wait();
      stall_drawn_at = results_seen;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    drive_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_drive_q.size() == 0) begin
        flag_error($sformatf("unexpected result drive=%0d clamped=%0b",
                             out_drive, out_clamped));
      end else begin
        want = expected_drive_q.pop_front();
        if (out_drive !== want.drive || out_clamped !== want.clamped)
          flag_error($sformatf("expected drive=%0d clamped=%0b, got drive=%0d clamped=%0b",
                               want.drive, want.clamped, out_drive, out_clamped));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cfg_model.gain_p = GAIN_P_RST;
    cfg_model.gain_i = GAIN_I_RST;
    cfg_model.gain_d = GAIN_D_RST;
    cfg_model.integrate_window = INT_WINDOW_RST;
    cfg_model.drive_limit = DRIVE_LIMIT_RST;
    cfg_model.marker_hold_enable = MARKER_HOLD_RST;
    integ_model = '0;
    prev_err_model = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: error extremes, window edges and the marker hold.
    queue_sample(0, 0, 1'b0);
    queue_sample(32767, -32768, 1'b0);
    queue_sample(-32768, 32767, 1'b0);
    queue_sample(1000, 101, 1'b0);
    queue_sample(1000, 100, 1'b0);
    queue_sample(-900, -1, 1'b0);
    queue_sample(100, -3, 1'b0);
    queue_sample(-3, -3, 1'b0);
    queue_sample(0, -3, 1'b0);
    queue_sample(32767, 32767, 1'b0);
    queue_sample(-32768, -32768, 1'b0);
    queue_sample(5000, 0, 1'b0);
    wait_drained(SETTLE_CYCLES);

    // Unity P and I gains with a zero window, so drive equals the error:
    // checks the limit boundary and that nothing integrates.
    load_settings(24'd16384, 24'd16384, 24'd0, 24'd0, 24'd100, 24'd0);
    write_reg(CFG_SPARE_LO, 24'hFFFFFF);
    write_reg(CFG_SPARE_HI, 24'h000001);
    queue_sample(100, 0, 1'b0);
    queue_sample(0, 100, 1'b0);
    queue_sample(101, 0, 1'b0);
    queue_sample(0, 101, 1'b0);
    queue_sample(0, 0, 1'b0);
    wait_drained(SETTLE_CYCLES);

    write_reg(CFG_DRIVE_LIMIT, 24'd0);
    queue_sample(0, 0, 1'b0);
    queue_sample(7, 0, 1'b0);
    queue_sample(0, 7, 1'b0);
    wait_drained(SETTLE_CYCLES);

    // Push the integral far positive and then far negative with the largest errors.
    no_idle = 1'b1;
    load_settings(24'd0, 24'hFFFFFF, 24'd0, 24'h00FFFF, 24'd32767, 24'd0);
    repeat (20) queue_sample(32767, -32767, 1'b0);
    repeat (40) queue_sample(-32767, 32767, 1'b0);
    wait_drained(SETTLE_CYCLES);
    no_idle = 1'b0;

    load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h00FFFF, 24'd32767, 24'd1);
    run_random_phase(75);
    load_settings(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    run_random_phase(75);
    for (int k = 0; k < 3; k++) begin
      no_idle = (k == 1);
      load_settings(pick_gain(), pick_gain(), pick_gain(),
                    {8'($urandom), ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                   : 16'($urandom_range(0, 4000))},
                    {9'($urandom), ($urandom_range(0, 3) == 0) ? 15'h7FFF
                                   : 15'($urandom)},
                    {23'($urandom), 1'($urandom)});
      run_random_phase(75);
    end
    no_idle = 1'b0;

    wait_drained(20);
    if (mismatch_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pwi_pkg.sv
hdl/pwi_integ.sv
hdl/pwi_mult.sv
hdl/pwi_drive.sv
hdl/pid_with_windowed_integral.sv
dv/tb_pid_with_windowed_integral.sv
